// ===== src/mlst_pkg.sv =====
// Shared types for the MAC learning switch table: the token that walks the
// cell chain and the result item. No dependencies.
`timescale 1ns / 1ps

package mlst_pkg;

   localparam int MacWidth  = 48;
   localparam int PortWidth = 3;
   localparam int MaskWidth = 8;
   localparam int CfgWidth  = 4;

   localparam logic [0:0] CmdForward = 1'b0;
   localparam logic [0:0] CmdClear   = 1'b1;

   localparam logic [MacWidth-1:0] BroadcastMac = {MacWidth{1'b1}};

   // Match state handed from one cell to the next.
   typedef struct packed {
      logic                 valid;
      logic                 src_hit;
      logic                 dst_hit;
      logic [PortWidth-1:0] dst_port;
   } token_type;

   typedef struct packed {
      logic [MaskWidth-1:0] port_mask;
      logic                 flooded;
      logic                 learned;
      logic                 table_full;
   } result_type;

endpackage

// ===== src/mlst_cell.sv =====
// One table entry of the MAC learning switch: stores a MAC and its port,
// matches the held query and passes the token to its neighbor. Uses mlst_pkg.
`timescale 1ns / 1ps

module mlst_cell #(
   parameter int TABLE_DEPTH = 16,
   parameter int INDEX       = 0
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mlst_pkg::token_type                   token_in,
   output mlst_pkg::token_type                   token_out,
   input  logic [mlst_pkg::MacWidth-1:0]         src_mac,
   input  logic [mlst_pkg::MacWidth-1:0]         dst_mac,
   input  logic [$clog2(TABLE_DEPTH+1)-1:0]      entry_count,
   input  logic                                  wr_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0]        wr_idx,
   input  logic [mlst_pkg::MacWidth-1:0]         wr_mac,
   input  logic [mlst_pkg::PortWidth-1:0]        wr_port
);

   localparam int CntW = $clog2(TABLE_DEPTH+1);
   localparam int IdxW = $clog2(TABLE_DEPTH);

   logic [mlst_pkg::MacWidth-1:0]  mac_ff;
   logic [mlst_pkg::PortWidth-1:0] port_ff;
   mlst_pkg::token_type            token_ff;
   mlst_pkg::token_type            token_in_next;
   logic                           live;
   logic                           src_match;
   logic                           dst_match;

   // Only entries below the fill count take part in a lookup.
   assign live      = CntW'(INDEX) < entry_count;
   assign src_match = live && (mac_ff == src_mac);
   assign dst_match = live && (mac_ff == dst_mac);

   always_comb begin
      token_in_next          = token_in;
      token_in_next.src_hit  = token_in.src_hit | src_match;
      token_in_next.dst_hit  = token_in.dst_hit | dst_match;
      token_in_next.dst_port = dst_match ? port_ff : token_in.dst_port;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff <= '0;
      end else begin
         token_ff <= token_in_next;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && (wr_idx == IdxW'(INDEX))) begin
         mac_ff  <= wr_mac;
         port_ff <= wr_port;
      end
   end

   assign token_out = token_ff;

endmodule

// ===== src/mlst_decide.sv =====
// Forwarding decision of the MAC learning switch: flood mask or learned port,
// with filtering on the ingress port; a clear gives an all-zero result. Uses mlst_pkg.
`timescale 1ns / 1ps

module mlst_decide #(
   parameter int NUM_PORTS = 8
) (
   input  logic                                clear,
   input  logic                                dst_known,
   input  logic [mlst_pkg::PortWidth-1:0]      known_port,
   input  logic [mlst_pkg::PortWidth-1:0]      ingress_port,
   input  logic [mlst_pkg::CfgWidth-1:0]       ports_in_use,
   input  logic                                learned,
   input  logic                                table_full,
   output mlst_pkg::result_type                result
);

   logic [mlst_pkg::MaskWidth-1:0] connected;
   logic [mlst_pkg::MaskWidth-1:0] ingress_bit;
   logic [mlst_pkg::MaskWidth-1:0] known_bit;

   always_comb begin
      for (int i = 0; i < mlst_pkg::MaskWidth; i++) begin
         connected[i] = (mlst_pkg::CfgWidth'(i) < ports_in_use) && (i < NUM_PORTS);
      end
   end

   assign ingress_bit = mlst_pkg::MaskWidth'(1) << ingress_port;
   assign known_bit   = mlst_pkg::MaskWidth'(1) << known_port;

   always_comb begin
      result = '0;
      if (!clear) begin
         result.learned    = learned;
         result.table_full = table_full;
         if (dst_known) begin
            // A destination learned on the ingress port is filtered.
            result.port_mask = (known_port == ingress_port) ? '0 : known_bit;
            result.flooded   = 1'b0;
         end else begin
            result.port_mask = connected & ~ingress_bit;
            result.flooded   = 1'b1;
         end
      end
   end

endmodule

// ===== src/mac_learning_switch_table_core.sv =====
// A forward frame header passes from the transfer through the start register and the chain
// of entry cells, the token walking one cell per cycle, then the hit and result registers.
// A clear command goes from the transfer straight to the result register. No new item is
// taken until the last one has reached the result register; a new item is taken while a result waits.
// Reset (synchronous): table empty, ports_in_use = 8, no result pending.
// Entry storage has no reset; entries beyond the fill count are never matched.
`timescale 1ns / 1ps

module mac_learning_switch_table_core #(
   parameter int TABLE_DEPTH = 16,
   parameter int NUM_PORTS   = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_command,
   input  logic [mlst_pkg::PortWidth-1:0]     req_ingress_port,
   input  logic [mlst_pkg::MacWidth-1:0]      req_source_mac,
   input  logic [mlst_pkg::MacWidth-1:0]      req_dest_mac,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [mlst_pkg::MaskWidth-1:0]     rsp_port_mask,
   output logic                               rsp_flooded,
   output logic                               rsp_learned,
   output logic                               rsp_table_full,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mlst_pkg::CfgWidth-1:0]      csr_data
);

   localparam int CntW = $clog2(TABLE_DEPTH+1);
   localparam int IdxW = $clog2(TABLE_DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type                       state_ff;
   logic                            start_ff;
   logic [CntW-1:0]                 count_ff;
   logic [mlst_pkg::CfgWidth-1:0]   ports_ff;
   logic                            q_clear_ff;
   logic [mlst_pkg::PortWidth-1:0]  q_ingress_ff;
   logic [mlst_pkg::MacWidth-1:0]   q_src_ff;
   logic [mlst_pkg::MacWidth-1:0]   q_dst_ff;
   logic                            hit_src_ff;
   logic                            hit_dst_ff;
   logic [mlst_pkg::PortWidth-1:0]  hit_port_ff;
   logic                            rsp_valid_ff;
   mlst_pkg::result_type            rsp_ff;

   mlst_pkg::token_type             chain_tok [0:TABLE_DEPTH];
   mlst_pkg::result_type            decided;
   logic                            req_take;
   logic                            fire;
   logic                            src_new;
   logic                            learn_now;
   logic                            full_now;
   logic                            dst_known;
   logic [mlst_pkg::PortWidth-1:0]  known_port;

   assign req_take  = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign fire      = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   assign src_new    = !q_clear_ff && !hit_src_ff;
   assign learn_now  = src_new && (count_ff < CntW'(TABLE_DEPTH));
   assign full_now   = src_new && !learn_now;
   // A destination equal to a source learned by this frame is known already.
   assign dst_known  = (q_dst_ff != mlst_pkg::BroadcastMac) &&
                       (hit_dst_ff || (learn_now && (q_dst_ff == q_src_ff)));
   assign known_port = hit_dst_ff ? hit_port_ff : q_ingress_ff;

   always_comb begin
      chain_tok[0]       = '0;
      chain_tok[0].valid = start_ff;
   end

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      mlst_cell #(
         .TABLE_DEPTH (TABLE_DEPTH),
         .INDEX       (g)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .token_in    (chain_tok[g]),
         .token_out   (chain_tok[g+1]),
         .src_mac     (q_src_ff),
         .dst_mac     (q_dst_ff),
         .entry_count (count_ff),
         .wr_en       (fire && learn_now),
         .wr_idx      (count_ff[IdxW-1:0]),
         .wr_mac      (q_src_ff),
         .wr_port     (q_ingress_ff)
      );
   end

   mlst_decide #(
      .NUM_PORTS (NUM_PORTS)
   ) u_decide (
      .clear        (q_clear_ff),
      .dst_known    (dst_known),
      .known_port   (known_port),
      .ingress_port (q_ingress_ff),
      .ports_in_use (ports_ff),
      .learned      (learn_now),
      .table_full   (full_now),
      .result       (decided)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         count_ff     <= '0;
         ports_ff     <= mlst_pkg::CfgWidth'(8);
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff <= req_take && (req_command != mlst_pkg::CmdClear);
         if (csr_valid && csr_ready) begin
            ports_ff <= csr_data;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  if (req_command == mlst_pkg::CmdClear) begin
                     state_ff <= ST_FINISH;
                  end else begin
                     state_ff <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               if (chain_tok[TABLE_DEPTH].valid) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (fire) begin
                  state_ff <= ST_IDLE;
                  if (q_clear_ff) begin
                     count_ff <= '0;
                  end else if (learn_now) begin
                     count_ff <= count_ff + CntW'(1);
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         q_clear_ff   <= (req_command == mlst_pkg::CmdClear);
         q_ingress_ff <= req_ingress_port;
         q_src_ff     <= req_source_mac;
         q_dst_ff     <= req_dest_mac;
      end
      if ((state_ff == ST_SCAN) && chain_tok[TABLE_DEPTH].valid) begin
         hit_src_ff  <= chain_tok[TABLE_DEPTH].src_hit;
         hit_dst_ff  <= chain_tok[TABLE_DEPTH].dst_hit;
         hit_port_ff <= chain_tok[TABLE_DEPTH].dst_port;
      end
      if (fire) begin
         rsp_ff <= decided;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_port_mask  = rsp_ff.port_mask;
   assign rsp_flooded    = rsp_ff.flooded;
   assign rsp_learned    = rsp_ff.learned;
   assign rsp_table_full = rsp_ff.table_full;

`ifndef SYNTHESIS
   a_take_blocks: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input side still open after a transfer");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(TABLE_DEPTH))
      else $error("fill count beyond table depth");

   a_learn_or_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_learned && rsp_table_full))
      else $error("learned and table_full both set");

   a_known_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_flooded |-> $onehot0(rsp_port_mask))
      else $error("known destination sent to more than one port");

   a_learn_counts: assert property (@(posedge clock) disable iff (reset)
      fire && learn_now |=> count_ff == $past(count_ff) + CntW'(1))
      else $error("learning did not advance the fill count");
`endif

endmodule
